### rtl/binomial_smooth_3x3_defines.svh
// Assertion macros shared by bs3_front, bs3_queue and bs3_back.
`ifndef BINOMIAL_SMOOTH_3X3_DEFINES_SVH
`define BINOMIAL_SMOOTH_3X3_DEFINES_SVH
`ifndef SYNTHESIS
`define BS3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BS3_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define BS3_ASSERT(lbl, prop)
`define BS3_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

### rtl/bs3_pkg.sv
`timescale 1ns / 1ps
package bs3_pkg;

  localparam int MAX_LINE_DEF     = 256;
  localparam int MAX_ROWS_DEF     = 4096;
  localparam int PIX_W            = 8;
  localparam int WIDTH_REG_W      = 9;
  localparam int HEIGHT_REG_W     = 13;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_IDX_W        = 1;
  localparam int FRAME_WIDTH_RST  = 256;
  localparam int FRAME_HEIGHT_RST = 256;
  localparam int SUM_W            = 12;
  localparam int ROUND_BIAS       = 7;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_word_t;

  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic                  border;
    logic                  row_end;
    logic                  frame_end;
  } win_job_t;

  typedef struct packed {
    logic           not_empty;
    logic [QCW-1:0] level;
  } q_stat_t;

endpackage

### rtl/bs3_front.sv
`timescale 1ns / 1ps
`include "binomial_smooth_3x3_defines.svh"
module bs3_front #(
  parameter int MAX_LINE = bs3_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = bs3_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  bs3_pkg::in_word_t                    in_word,
  input  logic                                 cfg_wr_en,
  input  logic [bs3_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bs3_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  bs3_pkg::q_stat_t                     q_stat,
  output logic                                 q_push,
  output bs3_pkg::win_job_t                    q_data
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int HW = $clog2(MAX_ROWS);
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int PW = bs3_pkg::PIX_W;
  localparam int W_RST_M1 =
    ((bs3_pkg::FRAME_WIDTH_RST > MAX_LINE) ? MAX_LINE : bs3_pkg::FRAME_WIDTH_RST) - 1;
  localparam int H_RST_M1 =
    ((bs3_pkg::FRAME_HEIGHT_RST > MAX_ROWS) ? MAX_ROWS : bs3_pkg::FRAME_HEIGHT_RST) - 1;

  logic [CW-1:0] w_m1_r, w_cfg;
  logic [HW-1:0] h_m1_r, h_cfg;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  logic          acc, take, h_reached, emit, col_last;
  logic          o_col_last, o_row_last, border, rend, fend;
  logic [PW-1:0] pix_v;

  logic          s1_valid_r, s1_emit_r, s1_border_r, s1_rend_r, s1_fend_r;
  logic [CW-1:0] s1_addr_r;
  logic [PW-1:0] s1_pix_r;
  logic          byp_r;
  logic [PW-1:0] byp_top_r, byp_mid_r, rd_top_r, rd_mid_r;
  logic [PW-1:0] top_eff, mid_eff;

  logic [PW-1:0] upper_mem [MAX_LINE];
  logic [PW-1:0] middle_mem [MAX_LINE];

  logic [8:0][PW-1:0] win_r, win_nxt;
  logic [bs3_pkg::QCW:0] pending;

  always_comb begin
    int wv;
    int hv;
    wv = int'(cfg_wdata[bs3_pkg::WIDTH_REG_W-1:0]);
    hv = int'(cfg_wdata[bs3_pkg::HEIGHT_REG_W-1:0]);
    if (wv < 1) begin
      wv = 1;
    end else if (wv > MAX_LINE) begin
      wv = MAX_LINE;
    end
    if (hv < 1) begin
      hv = 1;
    end else if (hv > MAX_ROWS) begin
      hv = MAX_ROWS;
    end
    w_cfg = CW'(wv - 1);
    h_cfg = HW'(hv - 1);
  end

  assign pending = (bs3_pkg::QCW + 1)'(q_stat.level) + (bs3_pkg::QCW + 1)'(s1_valid_r);
  assign in_full = pending >= (bs3_pkg::QCW + 1)'(bs3_pkg::QDEPTH);
  assign acc     = in_push && !in_full && !cfg_wr_en;

  assign h_reached = in_row_r > RW'(h_m1_r);
  assign take = acc && ((in_word.kind == bs3_pkg::KIND_FLUSH) ? h_reached : !h_reached);
  assign pix_v = (in_word.kind == bs3_pkg::KIND_FLUSH) ? '0 : in_word.pixel_in;

  assign emit = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
  assign col_last   = in_col_r == w_m1_r;
  assign o_col_last = out_col_r == w_m1_r;
  assign o_row_last = out_row_r == h_m1_r;
  assign border = (out_row_r == '0) || o_row_last || (out_col_r == '0) || o_col_last;
  assign rend   = o_col_last;
  assign fend   = o_col_last && o_row_last;

  always_comb begin
    in_col_nxt  = col_last ? '0 : in_col_r + CW'(1);
    in_row_nxt  = col_last ? in_row_r + RW'(1) : in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      if (fend) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (rend) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r     <= CW'(W_RST_M1);
      h_m1_r     <= HW'(H_RST_M1);
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      s1_valid_r <= take;
      if (cfg_wr_en) begin
        if (cfg_index == bs3_pkg::REG_FRAME_WIDTH) begin
          w_m1_r <= w_cfg;
        end
        if (cfg_index == bs3_pkg::REG_FRAME_HEIGHT) begin
          h_m1_r <= h_cfg;
        end
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        win_r     <= '0;
      end else begin
        if (take) begin
          in_col_r  <= in_col_nxt;
          in_row_r  <= in_row_nxt;
          out_col_r <= out_col_nxt;
          out_row_r <= out_row_nxt;
        end
        if (s1_valid_r) begin
          win_r <= win_nxt;
        end
      end
    end
  end

  assign top_eff = byp_r ? byp_top_r : rd_top_r;
  assign mid_eff = byp_r ? byp_mid_r : rd_mid_r;

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r   <= in_col_r;
      s1_pix_r    <= pix_v;
      s1_emit_r   <= emit;
      s1_border_r <= border;
      s1_rend_r   <= rend;
      s1_fend_r   <= fend;
      rd_top_r    <= upper_mem[in_col_r];
      rd_mid_r    <= middle_mem[in_col_r];
      byp_r       <= s1_valid_r && (s1_addr_r == in_col_r);
      byp_top_r   <= mid_eff;
      byp_mid_r   <= s1_pix_r;
    end
    if (s1_valid_r) begin
      upper_mem[s1_addr_r]  <= mid_eff;
      middle_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  always_comb begin
    win_nxt    = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[2] = top_eff;
    win_nxt[5] = mid_eff;
    win_nxt[8] = s1_pix_r;
  end

  assign q_push           = s1_valid_r && s1_emit_r;
  assign q_data.pix       = win_nxt;
  assign q_data.border    = s1_border_r;
  assign q_data.row_end   = s1_rend_r;
  assign q_data.frame_end = s1_fend_r;

  `BS3_ASSERT(a_bypass_column_zero, s1_valid_r && byp_r |-> s1_addr_r == '0)
  `BS3_ASSERT(a_frame_end_rewinds, take && emit && fend |=> in_row_r == '0 && out_row_r == '0)
  `BS3_ASSERT_MSG(a_no_overrun, q_push |-> q_stat.level < bs3_pkg::QCW'(bs3_pkg::QDEPTH),
                  "job queue overrun")

endmodule

### rtl/bs3_queue.sv
`timescale 1ns / 1ps
`include "binomial_smooth_3x3_defines.svh"
module bs3_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bs3_pkg::win_job_t push_data,
  input  logic              pop,
  output bs3_pkg::win_job_t head_data,
  output bs3_pkg::q_stat_t  stat
);

  bs3_pkg::win_job_t         mem_r [bs3_pkg::QDEPTH];
  logic [bs3_pkg::QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [bs3_pkg::QCW-1:0]   level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == bs3_pkg::QAW'(bs3_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_r + bs3_pkg::QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == bs3_pkg::QAW'(bs3_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_r + bs3_pkg::QAW'(1);
      end
      if (push && !pop) begin
        level_r <= level_r + bs3_pkg::QCW'(1);
      end else if (pop && !push) begin
        level_r <= level_r - bs3_pkg::QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data      = mem_r[rd_ptr_r];
  assign stat.not_empty = level_r != '0;
  assign stat.level     = level_r;

  `BS3_ASSERT_MSG(a_pop_nonempty, pop |-> level_r != '0, "pop from empty job queue")
  `BS3_ASSERT(a_ptr_level_agree, level_r == '0 |-> wr_ptr_r == rd_ptr_r)

endmodule

### rtl/bs3_back.sv
`timescale 1ns / 1ps
`include "binomial_smooth_3x3_defines.svh"
module bs3_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bs3_pkg::q_stat_t   q_stat,
  input  bs3_pkg::win_job_t  q_head,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output bs3_pkg::out_word_t out_word
);

  localparam int SW = bs3_pkg::SUM_W;

  logic                      out_valid_r;
  bs3_pkg::out_word_t        out_word_r, out_word_nxt;
  logic [SW-1:0]             sum;

  assign q_pop = q_stat.not_empty && (!out_valid_r || out_pop);

  assign sum = SW'(q_head.pix[0]) + SW'({q_head.pix[1], 1'b0})
             + SW'(q_head.pix[2]) + SW'({q_head.pix[3], 1'b0})
             + SW'({q_head.pix[4], 2'b00}) + SW'({q_head.pix[5], 1'b0})
             + SW'(q_head.pix[6]) + SW'({q_head.pix[7], 1'b0})
             + SW'(q_head.pix[8]) + SW'(bs3_pkg::ROUND_BIAS);

  always_comb begin
    out_word_nxt.pixel_out = q_head.border ? q_head.pix[4] : sum[SW-1:4];
    out_word_nxt.row_end   = q_head.row_end;
    out_word_nxt.frame_end = q_head.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_word  = out_word_r;

  `BS3_ASSERT(a_frame_end_is_row_end, out_valid_r && out_word_r.frame_end |-> out_word_r.row_end)

endmodule

### rtl/binomial_smooth_3x3.sv
// 3x3 binomial smoothing of a raster pixel stream (1-2-1 by 1-2-1 kernel).
// Input queue port: push/full with in_word {kind, pixel_in}; a word goes in
// when push is high and full is low. Pixel words carry the frame in raster
// order; flush words follow the last pixel and push out what is pending.
// Result queue port: empty/pop with out_word {pixel_out, row_end, frame_end};
// the head word is valid while empty is low and leaves when pop is high.
// Config port: cfg_wr_en/cfg_index/cfg_wdata; index 0 frame width, 1 frame
// height. A write restarts the frame; write only while the block is idle.
// Throughput: one word per clock while full is low, limited by the line-store
// port (one read and one write per clock). The result for pixel k comes out
// with the word k+width+1, so width+1 flush words drain a frame; that word's
// result passes the stage-1 register, the job queue and the output register.
// Border pixels pass unchanged; interior pixels get (sum+7)/16.
// Reset (rst_n low, synchronous) empties both queues, clears counters and
// the window and sets width and height to 256 (capped at MAX_LINE/MAX_ROWS).
// When the receiver stalls, results wait in a 4-entry job queue and the
// output register; full rises when they would overflow.
`timescale 1ns / 1ps
module binomial_smooth_3x3 #(
  parameter int MAX_LINE = bs3_pkg::MAX_LINE_DEF,
  parameter int MAX_ROWS = bs3_pkg::MAX_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  bs3_pkg::in_word_t              in_word,
  output logic                           out_empty,
  input  logic                           out_pop,
  output bs3_pkg::out_word_t             out_word,
  input  logic                           cfg_wr_en,
  input  logic [bs3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bs3_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic              q_push, q_pop;
  bs3_pkg::win_job_t q_wdata, q_head;
  bs3_pkg::q_stat_t  q_stat;

  bs3_front #(
    .MAX_LINE (MAX_LINE),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  bs3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head_data (q_head),
    .stat      (q_stat)
  );

  bs3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

### tb/binomial_smooth_3x3_tb.sv
`timescale 1ns / 1ps
module binomial_smooth_3x3_tb;

  localparam int MAX_LINE     = bs3_pkg::MAX_LINE_DEF;
  localparam int MAX_ROWS     = bs3_pkg::MAX_ROWS_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int TALL_ITEMS   = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 8;
  localparam int DRILL_N      = 26;

  typedef struct {
    bit                             do_cfg;
    logic [bs3_pkg::CFG_IDX_W-1:0]  idx;
    logic [bs3_pkg::CFG_DATA_W-1:0] data;
    bs3_pkg::in_word_t              word;
    bit                             pinned;
    bs3_pkg::out_word_t             typed;
  } drill_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_push;
  logic                           in_full;
  bs3_pkg::in_word_t              in_word;
  logic                           out_empty;
  logic                           out_pop;
  bs3_pkg::out_word_t             out_word;
  logic                           cfg_wr_en;
  logic [bs3_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bs3_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bit                 pin_valid;
  bs3_pkg::out_word_t pin_word;
  bit                 steady;
  bit                 hold_req;

  logic [bs3_pkg::PIX_W-1:0] upper_line  [MAX_LINE];
  logic [bs3_pkg::PIX_W-1:0] middle_line [MAX_LINE];
  logic [bs3_pkg::PIX_W-1:0] win [9];
  int unsigned in_col, in_row, out_col, out_row, width_px, height_px;

  bs3_pkg::out_word_t smoothed_q [$];
  int words_in;
  int words_out;
  int mismatches;
  int stall_cycles;
  int phase;

  drill_row_t drill [DRILL_N] = '{
    '{1'b1, bs3_pkg::REG_FRAME_WIDTH,  13'h1e00, '0, 1'b0, '0},
    '{1'b1, bs3_pkg::REG_FRAME_HEIGHT, 13'h0000, '0, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'hff}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b1, {8'hff, 1'b1, 1'b1}},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'hff}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h5a}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'ha5}, 1'b1, {8'h00, 1'b1, 1'b1}},
    '{1'b1, bs3_pkg::REG_FRAME_WIDTH,  13'd3, '0, 1'b0, '0},
    '{1'b1, bs3_pkg::REG_FRAME_HEIGHT, 13'd3, '0, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'hff}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'hff}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'hff}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'hff}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h80}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_PIXEL, 8'h55}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b0, '0},
    '{1'b0, '0, '0, {bs3_pkg::KIND_FLUSH, 8'h00}, 1'b0, '0}
  };

  binomial_smooth_3x3 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int unsigned clamp_reg(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < 9; i++) win[i] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void smooth_reset();
    for (int i = 0; i < MAX_LINE; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    restart_frame();
    width_px  = clamp_reg(bs3_pkg::FRAME_WIDTH_RST, MAX_LINE);
    height_px = clamp_reg(bs3_pkg::FRAME_HEIGHT_RST, MAX_ROWS);
  endfunction

  function automatic void load_reg(input logic [bs3_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [bs3_pkg::CFG_DATA_W-1:0] data);
    if (idx == bs3_pkg::REG_FRAME_WIDTH) begin
      width_px = clamp_reg(data[bs3_pkg::WIDTH_REG_W-1:0], MAX_LINE);
      restart_frame();
    end else if (idx == bs3_pkg::REG_FRAME_HEIGHT) begin
      height_px = clamp_reg(data[bs3_pkg::HEIGHT_REG_W-1:0], MAX_ROWS);
      restart_frame();
    end
  endfunction

  function automatic void smooth_step(input bs3_pkg::in_word_t w, output bit taken,
                                      output bit emit, output bs3_pkg::out_word_t r);
    bit                        flush;
    logic [bs3_pkg::PIX_W-1:0] v;
    logic [bs3_pkg::PIX_W-1:0] top;
    logic [bs3_pkg::PIX_W-1:0] mid;
    bit                        border;
    bit                        rend;
    bit                        fend;
    int unsigned               s;
    taken = 1'b0;
    emit  = 1'b0;
    r     = '0;
    flush = (w.kind == bs3_pkg::KIND_FLUSH);
    if (!flush && in_row >= height_px) return;
    if (flush && in_row < height_px) return;
    taken = 1'b1;
    v = flush ? '0 : w.pixel_in;
    top = upper_line[in_col];
    mid = middle_line[in_col];
    upper_line[in_col]  = mid;
    middle_line[in_col] = v;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= width_px) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    border = (out_row == 0) || (out_row == height_px - 1) ||
             (out_col == 0) || (out_col == width_px - 1);
    if (border) begin
      r.pixel_out = win[4];
    end else begin
      s = win[0] + 2 * win[1] + win[2] + 2 * win[3] + 4 * win[4] + 2 * win[5]
        + win[6] + 2 * win[7] + win[8] + bs3_pkg::ROUND_BIAS;
      r.pixel_out = bs3_pkg::PIX_W'(s / 16);
    end
    rend = (out_col == width_px - 1);
    fend = rend && (out_row == height_px - 1);
    r.row_end   = rend;
    r.frame_end = fend;
    if (fend) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else if (rend) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  task automatic compare_word(input bs3_pkg::out_word_t got);
    bs3_pkg::out_word_t want;
    if (smoothed_q.size() == 0) begin
      $display("%0t unexpected word: expected none, actual %0h/%0b/%0b", $time,
               got.pixel_out, got.row_end, got.frame_end);
      mismatches++;
      return;
    end
    want = smoothed_q.pop_front();
    if (got.pixel_out !== want.pixel_out) begin
      $display("%0t pixel_out mismatch: expected %0h, actual %0h", $time,
               want.pixel_out, got.pixel_out);
      mismatches++;
    end
    if (got.row_end !== want.row_end) begin
      $display("%0t row_end mismatch: expected %0b, actual %0b", $time,
               want.row_end, got.row_end);
      mismatches++;
    end
    if (got.frame_end !== want.frame_end) begin
      $display("%0t frame_end mismatch: expected %0b, actual %0b", $time,
               want.frame_end, got.frame_end);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    bit                 taken;
    bit                 emit;
    bs3_pkg::out_word_t r;
    if (!rst_n) begin
      smooth_reset();
      stall_cycles <= 0;
    end else begin
      if (!out_empty && out_pop) begin
        compare_word(out_word);
        words_out++;
      end
      if (cfg_wr_en) load_reg(cfg_index, cfg_wdata);
      if (in_push && !in_full) begin
        smooth_step(in_word, taken, emit, r);
        if (taken) words_in++;
        if (pin_valid && !emit) begin
          $display("%0t word with typed result: expected %0h, actual none", $time,
                   pin_word.pixel_out);
          mismatches++;
        end
        if (emit) smoothed_q.push_back(pin_valid ? pin_word : r);
      end
      if ((in_push && !in_full) || (!out_empty && out_pop) || cfg_wr_en) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_pop <= steady || ($urandom_range(0, 99) >= 34);
      end
    end
  end

  function automatic logic [bs3_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return bs3_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic push_word(input bs3_pkg::in_word_t w, input bit pin_on,
                           input bs3_pkg::out_word_t pin_val);
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push   <= 1'b1;
    in_word   <= w;
    pin_valid <= pin_on;
    pin_word  <= pin_val;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic settle();
    in_push   <= 1'b0;
    pin_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bs3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bs3_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // stray flushes before the frame completes and stray pixels before its
  // last result are both dropped by the block
  task automatic send_frame(input int fw, input int fh, input int noise);
    for (int i = 0; i < fw * fh; i++) begin
      if ($urandom_range(0, 99) < noise) begin
        push_word({bs3_pkg::KIND_FLUSH, pick_pixel()}, 1'b0, '0);
      end
      push_word({bs3_pkg::KIND_PIXEL, pick_pixel()}, 1'b0, '0);
    end
    for (int i = 0; i <= fw; i++) begin
      if ($urandom_range(0, 99) < noise) begin
        push_word({bs3_pkg::KIND_PIXEL, pick_pixel()}, 1'b0, '0);
      end
      push_word({bs3_pkg::KIND_FLUSH, pick_pixel()}, 1'b0, '0);
    end
  endtask

  initial begin
    int                             base;
    int                             fw;
    int                             fh;
    int                             nframes;
    int                             nbroken;
    logic [bs3_pkg::CFG_DATA_W-1:0] wdata;
    logic [bs3_pkg::CFG_DATA_W-1:0] hdata;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_word    = '0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    pin_valid  = 1'b0;
    pin_word   = '0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    words_in   = 0;
    words_out  = 0;
    mismatches = 0;
    phase      = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (drill[i]) begin
      if (drill[i].do_cfg) begin
        settle();
        write_reg(drill[i].idx, drill[i].data);
      end else begin
        push_word(drill[i].word, drill[i].pinned, drill[i].typed);
      end
    end

    // widest line, overflowing width value; receiver holds off to back up the input
    settle();
    write_reg(bs3_pkg::REG_FRAME_WIDTH, 13'h01ff);
    write_reg(bs3_pkg::REG_FRAME_HEIGHT, 13'd3);
    hold_req = 1'b1;
    send_frame(MAX_LINE, 3, 2);

    // tallest frame, overflowing height value; cut short by the next restart
    settle();
    write_reg(bs3_pkg::REG_FRAME_WIDTH, 13'd1);
    write_reg(bs3_pkg::REG_FRAME_HEIGHT, 13'h1fff);
    for (int i = 0; i < TALL_ITEMS; i++) begin
      push_word({bs3_pkg::KIND_PIXEL, pick_pixel()}, 1'b0, '0);
    end

    base = words_in;
    while (words_in - base < RANDOM_ITEMS) begin
      phase++;
      steady = (phase >= 2 && phase < 5);
      if ($urandom_range(0, 9) == 0) begin
        fw = $urandom_range(13, 40);
        fh = $urandom_range(1, 3);
      end else begin
        fw = $urandom_range(1, 12);
        fh = $urandom_range(1, 8);
      end
      wdata = {4'($urandom), 9'(fw)};
      hdata = 13'(fh);
      if (fw == 1 && $urandom_range(0, 1) == 1) wdata[8:0] = '0;
      if (fh == 1 && $urandom_range(0, 1) == 1) hdata = '0;
      settle();
      if ($urandom_range(0, 1) == 1) begin
        write_reg(bs3_pkg::REG_FRAME_WIDTH, wdata);
        write_reg(bs3_pkg::REG_FRAME_HEIGHT, hdata);
      end else begin
        write_reg(bs3_pkg::REG_FRAME_HEIGHT, hdata);
        write_reg(bs3_pkg::REG_FRAME_WIDTH, wdata);
      end
      nframes = $urandom_range(1, 3);
      for (int k = 0; k < nframes; k++) begin
        if ($urandom_range(0, 99) < 12) begin
          nbroken = $urandom_range(1, fw * fh + fw);
          for (int j = 0; j < nbroken; j++) begin
            push_word({1'($urandom), pick_pixel()}, 1'b0, '0);
          end
          break;
        end
        send_frame(fw, fh, 4);
      end
    end
    steady = 1'b0;

    settle();
    repeat (2 * SETTLE_WAIT) @(negedge clk);
    $display("covered %0d words in and %0d results over %0d random phases,", words_in,
             words_out, phase);
    $display("from 1x1 frames to a 256-wide one and the start of a 4096-row one, both sides stalled");
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
